// ===== rtl/core/eias_pkg.sv =====
`timescale 1ns / 1ps

package eias_pkg;

    // Width of the signed span inputs
    localparam int VALUE_WIDTH = 32;
    // Largest supported step is 2 * 10^MAX_DECADE
    localparam int MAX_DECADE  = 10;

    // Output field widths
    localparam int AXIS_W   = 41;
    localparam int STEP_O_W = 35;
    localparam int COUNT_W  = 8;

    function automatic longint unsigned pow10(input int d);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < d; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam longint unsigned STEP_LIMIT = 2 * pow10(MAX_DECADE);
    // Wide enough for the first nice value past the limit
    localparam int STEP_W = $clog2(5 * pow10(MAX_DECADE) + 1);

    // Internal signed width for axis arithmetic
    localparam int AX_SUM = VALUE_WIDTH + STEP_W + COUNT_W + 2;
    localparam int AX_W   = (AX_SUM > AXIS_W + 1) ? AX_SUM : AXIS_W + 1;

    localparam int DIV_CNT_W = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_RANGE   = 2'd2
    } eias_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_DIV,
        ST_DIV_WAIT,
        ST_TRIAL,
        ST_CALC,
        ST_DONE
    } eias_state_t;

    // Controller to datapath
    typedef struct packed {
        logic         in_ready;
        logic         load;
        logic         advance;
        logic         div_start;
        logic         calc;
        logic         write;
        eias_status_t code;
    } eias_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic invalid;
        logic too_big;
        logic covered;
        logic fits;
        logic div_busy;
        logic out_free;
    } eias_stat_t;

endpackage

// ===== rtl/core/eias_in_if.sv =====
`timescale 1ns / 1ps

interface eias_in_if
    import eias_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] span_low;
    logic signed [VALUE_WIDTH-1:0] span_high;
    logic        [COUNT_W-1:0]     interval_count;

    modport source (output valid, output span_low, output span_high,
                    output interval_count, input ready);
    modport sink   (input valid, input span_low, input span_high,
                    input interval_count, output ready);
endinterface

// ===== rtl/core/eias_out_if.sv =====
`timescale 1ns / 1ps

interface eias_out_if
    import eias_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] axis_low;
    logic signed [AXIS_W-1:0] axis_high;
    logic [STEP_O_W-1:0]      step_size;
    logic [1:0]               status;

    modport source (output valid, output axis_low, output axis_high,
                    output step_size, output status, input ready);
    modport sink   (input valid, input axis_low, input axis_high,
                    input step_size, input status, output ready);
endinterface

// ===== rtl/core/exact_interval_axis_scale_core.sv =====
`timescale 1ns / 1ps

// Linear axis scaler: for a signed span and an interval count n, picks the
// smallest step of 1, 2 or 5 times a power of ten whose n steps hold the
// floored low and ceiled high bounds, centers leftover steps, and returns the
// axis limits, the step and a status (ok, invalid input, step out of range).
// One word is handled at a time. An item passes through a check, a coverage
// search over the nice steps, and trial divisions (two 1-bit-per-cycle
// restoring dividers run in parallel on the low and high bound), then
// finishing states. Invalid input skips the search and the divisions.
// The result sits in an output register, so a new word is taken while the
// last one waits.
module exact_interval_axis_scale_core
    import eias_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    eias_in_if.sink    span,
    eias_out_if.source axis
);

    eias_cmd_t  cmd;
    eias_stat_t stat;

    eias_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    eias_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .span  (span),
        .axis  (axis)
    );

endmodule

// ===== rtl/core/eias_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module eias_divider
    import eias_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [STEP_W-1:0]      divisor,
    output logic                   busy,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [STEP_W-1:0]      remainder
);

    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]      rem_reg, rem_next;
    logic [STEP_W:0]        rem_shift;
    logic [STEP_W:0]        rem_diff;
    logic                   ge;

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // Shift in one dividend bit and trial subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        ge        = (rem_shift >= {1'b0, divisor});
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(VALUE_WIDTH);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_next = ge ? rem_diff[STEP_W-1:0] : rem_shift[STEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== rtl/core/eias_datapath.sv =====
`timescale 1ns / 1ps

module eias_datapath
    import eias_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  eias_cmd_t       cmd,
    output eias_stat_t      stat,
    eias_in_if.sink         span,
    eias_out_if.source      axis
);

    logic signed [VALUE_WIDTH-1:0] lo_reg, hi_reg;
    logic [COUNT_W-1:0]            n_reg;
    logic [1:0]                    k_reg, k_next;
    logic [STEP_W-1:0]             p_reg, p_next;
    logic [STEP_W-1:0]             s;
    logic signed [AX_W-1:0]        alow_reg;

    logic                          out_valid_reg;
    logic signed [AXIS_W-1:0]      out_low_reg, out_high_reg;
    logic [STEP_O_W-1:0]           out_step_reg;
    logic [1:0]                    out_status_reg;

    logic signed [AX_W-1:0] lo_x, hi_x, span_x, ns_x, n_x, s_x;
    logic [COUNT_W+STEP_W-1:0] ns_u, nxs_u;
    logic [VALUE_WIDTH-1:0] lo_mag, hi_mag;
    logic                   lo_busy, hi_busy;
    logic [VALUE_WIDTH-1:0] lo_q, hi_q;
    logic [STEP_W-1:0]      lo_r, hi_r;
    logic                   lo_nz, hi_nz;
    logic signed [AX_W-1:0] m1, m2, np, rfloor, nx, alow_calc, ahigh;
    logic signed [AX_W-1:0] diff;

    // Current nice step from mantissa index and decade
    always_comb
    begin
        unique case (k_reg)
            2'd0:    s = p_reg;
            2'd1:    s = p_reg << 1;
            default: s = (p_reg << 2) + p_reg;
        endcase
    end

    always_comb
    begin
        lo_x   = AX_W'(lo_reg);
        hi_x   = AX_W'(hi_reg);
        span_x = hi_x - lo_x;
        n_x    = AX_W'({1'b0, n_reg});
        s_x    = AX_W'({1'b0, s});
        ns_u   = n_reg * s;
        ns_x   = AX_W'(ns_u);
        lo_mag = lo_reg[VALUE_WIDTH-1] ? VALUE_WIDTH'(-lo_x) : lo_reg;
        hi_mag = hi_reg[VALUE_WIDTH-1] ? VALUE_WIDTH'(-hi_x) : hi_reg;
    end

    eias_divider u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (lo_mag),
        .divisor   (s),
        .busy      (lo_busy),
        .quotient  (lo_q),
        .remainder (lo_r)
    );

    eias_divider u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (hi_mag),
        .divisor   (s),
        .busy      (hi_busy),
        .quotient  (hi_q),
        .remainder (hi_r)
    );

    // Floor of low bound, ceiling of high bound, and leftover split
    always_comb
    begin
        lo_nz = (lo_r != '0);
        hi_nz = (hi_r != '0);
        if (lo_reg[VALUE_WIDTH-1])
        begin
            m1     = -AX_W'({1'b0, lo_q}) - AX_W'({1'b0, lo_nz});
            rfloor = lo_nz ? s_x - AX_W'({1'b0, lo_r}) : '0;
        end
        else
        begin
            m1     = AX_W'({1'b0, lo_q});
            rfloor = AX_W'({1'b0, lo_r});
        end
        if (hi_reg[VALUE_WIDTH-1])
        begin
            m2 = -AX_W'({1'b0, hi_q});
        end
        else
        begin
            m2 = AX_W'({1'b0, hi_q}) + AX_W'({1'b0, hi_nz});
        end
        np        = m2 - m1;
        diff      = n_x - np;
        nx        = diff >>> 1;
        nxs_u     = nx[COUNT_W-1:0] * s;
        alow_calc = lo_x - rfloor - AX_W'(nxs_u);
        ahigh     = alow_reg + ns_x;
    end

    always_comb
    begin
        stat.in_valid = span.valid;
        stat.invalid  = (lo_reg >= hi_reg) || (n_reg == '0);
        stat.too_big  = ({1'b0, s} > (STEP_W + 1)'(STEP_LIMIT));
        stat.covered  = (ns_x >= span_x);
        stat.fits     = (np <= n_x);
        stat.div_busy = lo_busy || hi_busy;
        stat.out_free = !out_valid_reg || axis.ready;
    end

    // Reset to a step of 1 on load, else step to next nice value
    always_comb
    begin
        k_next = k_reg;
        p_next = p_reg;
        if (cmd.load)
        begin
            k_next = 2'd0;
            p_next = STEP_W'(1);
        end
        else if (cmd.advance)
        begin
            if (k_reg == 2'd2)
            begin
                k_next = 2'd0;
                p_next = (p_reg << 3) + (p_reg << 1);
            end
            else
            begin
                k_next = k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        p_reg <= p_next;
        if (cmd.load)
        begin
            lo_reg <= span.span_low;
            hi_reg <= span.span_high;
            n_reg  <= span.interval_count;
        end
        if (cmd.calc)
        begin
            alow_reg <= alow_calc;
        end
        if (cmd.write)
        begin
            out_status_reg <= cmd.code;
            if (cmd.code == STATUS_OK)
            begin
                out_low_reg  <= AXIS_W'(alow_reg);
                out_high_reg <= AXIS_W'(ahigh);
                out_step_reg <= STEP_O_W'(s);
            end
            else
            begin
                out_low_reg  <= '0;
                out_high_reg <= '0;
                out_step_reg <= '0;
            end
        end
    end

    // Hold result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (axis.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign span.ready     = cmd.in_ready;
    assign axis.valid     = out_valid_reg;
    assign axis.axis_low  = out_low_reg;
    assign axis.axis_high = out_high_reg;
    assign axis.step_size = out_step_reg;
    assign axis.status    = out_status_reg;

endmodule

// ===== rtl/core/eias_controller.sv =====
`timescale 1ns / 1ps

module eias_controller
    import eias_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  eias_stat_t stat,
    output eias_cmd_t  cmd
);

    eias_state_t  state_reg, state_next;
    eias_status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            code_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        cmd           = '0;
        cmd.code      = code_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.invalid)
                begin
                    code_next  = STATUS_INVALID;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            // Grow the step until n steps cover the span or it passes the limit
            ST_SEARCH:
            begin
                if (stat.too_big)
                begin
                    code_next  = STATUS_RANGE;
                    state_next = ST_DONE;
                end
                else if (!stat.covered)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.too_big)
                begin
                    code_next  = STATUS_RANGE;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_TRIAL;
                end
            end
            // Retry with the next nice step when too many steps result
            ST_TRIAL:
            begin
                if (stat.fits)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                code_next  = STATUS_OK;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
